// ===== src/pcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg: shared types, constants and table function
// Shape codes, register indexes, datapath widths, the controller/datapath
// command and status structs, and the Q1.15 sine entry generator.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // default parameter values
  localparam int SineDepthDefault = 1024;
  localparam int CoordBitsDefault = 14;

  // sweep length
  localparam int MaxSteps  = 256;
  localparam int HalfSteps = MaxSteps / 2;
  localparam int StepBits  = $clog2(MaxSteps);

  // configuration port
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 12;
  localparam int ShapeBits    = 3;
  localparam int CenterBits   = 12;

  localparam logic [CfgIndexBits-1:0] CfgShape   = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgCenterX = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgCenterY = 2'd2;

  localparam logic [ShapeBits-1:0] ShapeAstroid = 3'd0;
  localparam logic [ShapeBits-1:0] ShapeCircle  = 3'd1;
  localparam logic [ShapeBits-1:0] ShapeHuygens = 3'd2;
  localparam logic [ShapeBits-1:0] ShapeHypo    = 3'd3;
  localparam logic [ShapeBits-1:0] ShapeLine    = 3'd4;

  localparam logic [ShapeBits-1:0]  ShapeReset   = ShapeAstroid;
  localparam logic [CenterBits-1:0] CenterXReset = 12'd199;
  localparam logic [CenterBits-1:0] CenterYReset = 12'd99;

  // datapath widths; every point is carried with 45 fraction bits
  localparam int SampleBits   = 16;
  localparam int ProdBits     = 32;
  localparam int MulBits      = ProdBits + SampleBits;
  localparam int CubeBits     = 46;
  localparam int FracBits     = 45;
  localparam int SumBits      = 60;
  localparam int SatBits      = 17;
  localparam int CircleShift  = FracBits - 15;
  localparam int HuygensShift = FracBits - 15 + 4;
  localparam int HypoShift    = FracBits - 16;
  localparam int LineShift    = FracBits - (StepBits - 1);

  typedef struct packed {
    logic load;
    logic look;
    logic mul_en;
    logic mul_cube;
    logic mul_axis;
    logic sum;
    logic finish;
  } pcs_cmd_t;

  typedef struct packed {
    logic astroid;
  } pcs_status_t;

  // Entry idx of a sine table of 2**dlog entries, Q1.15, built from a
  // Q30 Taylor series of degree 13 on the angle folded into one quadrant.
  function automatic logic [SampleBits-1:0] sine_entry(input int unsigned idx,
                                                       input int unsigned dlog);
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] q;
    logic [1:0]  quad;
    int          n;
    f = {32'(idx), 32'd0} >> dlog;
    quad = f[31:30];
    r = f & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = '0;
    for (n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    q = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    sine_entry = quad[1] ? SampleBits'(-q) : SampleBits'(q);
  endfunction

endpackage

// ===== src/pcs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_if: item channels of the curve sweep
// Input item channel, result item channel and register write channel, each a
// valid/ready handshake with source and sink views.
// ----------------------------------------------------------------------------
interface pcs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface pcs_out_if #(
  parameter int COORD_BITS = pcs_pkg::CoordBitsDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] from_x;
  logic signed [COORD_BITS-1:0] from_y;
  logic signed [COORD_BITS-1:0] to_x;
  logic signed [COORD_BITS-1:0] to_y;
  logic                         last;

  modport source (output valid, output from_x, output from_y, output to_x,
                  output to_y, output last, input ready);
  modport sink (input valid, input from_x, input from_y, input to_x,
                input to_y, input last, output ready);
endinterface

interface pcs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pcs_pkg::CfgIndexBits-1:0]     index;
  logic [pcs_pkg::CfgDataBits-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/pcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ctrl: sequencer of the curve sweep
// Walks one item through table lookup, the shared multiplier (astroid only),
// the wide sum and rounding, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pcs_pkg::pcs_status_t status_i,
  output pcs_pkg::pcs_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_SQ_X = 3'd2;
  localparam logic [2:0] ST_CU_X = 3'd3;
  localparam logic [2:0] ST_SQ_Y = 3'd4;
  localparam logic [2:0] ST_CU_Y = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_RND  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = status_i.astroid ? ST_SQ_X : ST_SUM;
      end
      ST_SQ_X: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_CU_X;
      end
      ST_CU_X: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_cube = 1'b1;
        state_d        = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = 1'b1;
        state_d        = ST_CU_Y;
      end
      ST_CU_Y: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_cube = 1'b1;
        cmd_o.mul_axis = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        // hold the rounded point until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.finish | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/pcs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_dp: datapath of the curve sweep
// Registers, step counter, phase, quarter-wave sine table, shared multiplier,
// wide sum, half-away rounding and saturation, result registers.
// ----------------------------------------------------------------------------
module pcs_dp #(
  parameter int SINE_TABLE_DEPTH = pcs_pkg::SineDepthDefault,
  parameter int COORD_BITS       = pcs_pkg::CoordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcs_pkg::pcs_cmd_t                   cmd_i,
  output pcs_pkg::pcs_status_t                status_o,
  input  logic                                restart_i,
  input  logic                                cfg_we_i,
  input  logic [pcs_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [pcs_pkg::CfgDataBits-1:0]     cfg_data_i,
  output logic signed [COORD_BITS-1:0]        from_x_o,
  output logic signed [COORD_BITS-1:0]        from_y_o,
  output logic signed [COORD_BITS-1:0]        to_x_o,
  output logic signed [COORD_BITS-1:0]        to_y_o,
  output logic                                last_o
);

  localparam int DLOG = $clog2(SINE_TABLE_DEPTH);
  localparam int QLOG = DLOG - 2;
  localparam int QD   = SINE_TABLE_DEPTH / 4;
  localparam int SB   = pcs_pkg::StepBits;
  localparam int PW   = DLOG + SB + 2;
  localparam int SW   = pcs_pkg::SampleBits;
  localparam int TW   = pcs_pkg::SumBits;
  localparam int RW   = pcs_pkg::SatBits;

  localparam logic [SW-1:0] PEAK = pcs_pkg::sine_entry(QD, DLOG);
  localparam logic [SB-1:0] LAST_FULL = SB'(pcs_pkg::MaxSteps - 1);
  localparam logic [SB-1:0] LAST_HALF = SB'(pcs_pkg::HalfSteps - 1);
  localparam logic signed [TW-1:0] HALF_ULP = TW'(64'd1 << (pcs_pkg::FracBits - 1));
  localparam logic signed [RW-1:0] PIX_HI = RW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] PIX_LO = -PIX_HI - RW'(1);

  // first quadrant of the sine table; the quarter-wave peak is kept apart
  logic [SW-1:0] qtab [QD];
  for (genvar g = 0; g < QD; g++) begin : g_qtab
    localparam logic [SW-1:0] Entry = pcs_pkg::sine_entry(g, DLOG);
    assign qtab[g] = Entry;
  end

  function automatic logic signed [SW-1:0] sine_at(input logic [DLOG-1:0] ph);
    logic [1:0]      quad;
    logic [QLOG:0]   rf;
    logic [SW-1:0]   mag;
    quad = ph[DLOG-1 -: 2];
    if (quad[0]) begin
      rf = (QLOG+1)'(QD) - {1'b0, ph[QLOG-1:0]};
    end else begin
      rf = {1'b0, ph[QLOG-1:0]};
    end
    mag = rf[QLOG] ? PEAK : qtab[rf[QLOG-1:0]];
    sine_at = quad[1] ? -mag : mag;
  endfunction

  // one axis of the point, scaled to 45 fraction bits, plus its center
  function automatic logic signed [TW-1:0] axis_sum(
    input logic [pcs_pkg::ShapeBits-1:0]     shp,
    input logic signed [SW-1:0]              a,
    input logic signed [SW-1:0]              am,
    input logic signed [pcs_pkg::CubeBits-1:0] cube,
    input logic                              is_y,
    input logic [SB:0]                       n,
    input logic [pcs_pkg::CenterBits-1:0]    ctr
  );
    logic signed [TW-1:0] ae;
    logic signed [TW-1:0] ame;
    logic signed [TW-1:0] ce;
    logic signed [TW-1:0] ne;
    logic signed [TW-1:0] d;
    logic signed [TW-1:0] v;
    logic signed [TW-1:0] cc;
    ae  = a;
    ame = am;
    ce  = cube;
    ne  = TW'(n);
    cc  = TW'(ctr);
    d   = '0;
    case (shp)
      pcs_pkg::ShapeAstroid: begin
        v = (ce <<< 6) + (ce <<< 4);
      end
      pcs_pkg::ShapeCircle: begin
        v = ((ae <<< 5) + (ae <<< 3)) <<< pcs_pkg::CircleShift;
      end
      pcs_pkg::ShapeHuygens: begin
        d = (ae <<< 1) + ae - ame;
        v = d <<< pcs_pkg::HuygensShift;
      end
      pcs_pkg::ShapeHypo: begin
        d = is_y ? (ae <<< 1) - ame : (ae <<< 1) + ame;
        v = ((d <<< 5) + (d <<< 3) + (d <<< 2) + d) <<< pcs_pkg::HypoShift;
      end
      pcs_pkg::ShapeLine: begin
        v = ((ne <<< 5) + (ne <<< 4) + (ne <<< 1)) <<< pcs_pkg::LineShift;
      end
      default: begin
        v = '0;
      end
    endcase
    axis_sum = v + (cc <<< pcs_pkg::FracBits);
  endfunction

  // round half away from zero on the 45 fraction bits, then saturate
  function automatic logic signed [COORD_BITS-1:0] to_pixel(
    input logic signed [TW-1:0] t
  );
    logic signed [TW-1:0] tr;
    logic signed [RW-1:0] re;
    tr = t + (t[TW-1] ? HALF_ULP - TW'(1) : HALF_ULP);
    re = RW'(signed'(tr[TW-1:pcs_pkg::FracBits]));
    if (re > PIX_HI) begin
      re = PIX_HI;
    end else if (re < PIX_LO) begin
      re = PIX_LO;
    end
    to_pixel = COORD_BITS'(re);
  endfunction

  // configuration and sweep state
  logic [pcs_pkg::ShapeBits-1:0]  shape_q;
  logic [pcs_pkg::CenterBits-1:0] center_x_q;
  logic [pcs_pkg::CenterBits-1:0] center_y_q;
  logic [SB-1:0]                  step_q, step_d;

  // per-item registers
  logic [SB-1:0]                  k_q;
  logic                           last_q;
  logic [DLOG-1:0]                p_q;
  logic signed [SW-1:0]           c_q, s_q, cm_q, sm_q;
  logic signed [pcs_pkg::ProdBits-1:0] prod_q;
  logic signed [pcs_pkg::CubeBits-1:0] cx3_q, cy3_q;
  logic signed [TW-1:0]           tx_q, ty_q;
  logic signed [COORD_BITS-1:0]   prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0]   from_x_q, from_y_q, to_x_q, to_y_q;
  logic                           out_last_q;

  // item entry: step, phase and last flag
  logic                 full_steps;
  logic [SB-1:0]        k_raw, k_new;
  logic                 last_new;
  logic [1:0]           turns;
  logic [SB+1:0]        kt;
  logic [PW-1:0]        ph_full, ph_half;
  logic [DLOG-1:0]      p_new;

  assign full_steps = (shape_q == pcs_pkg::ShapeAstroid) ||
                      (shape_q == pcs_pkg::ShapeHuygens) ||
                      (shape_q == pcs_pkg::ShapeHypo);

  always_comb begin
    case (shape_q)
      pcs_pkg::ShapeAstroid: turns = 2'd1;
      pcs_pkg::ShapeCircle:  turns = 2'd3;
      pcs_pkg::ShapeHuygens: turns = 2'd2;
      pcs_pkg::ShapeHypo:    turns = 2'd1;
      default:               turns = 2'd0;
    endcase
  end

  always_comb begin
    k_raw = restart_i ? '0 : step_q;
    // a shorter sweep than the stored step restarts at step zero
    k_new = (!full_steps && k_raw[SB-1]) ? '0 : k_raw;
    last_new = full_steps ? (k_new == LAST_FULL) : (k_new == LAST_HALF);
    kt = (SB+2)'(k_new) * (SB+2)'(turns);
    ph_full = PW'(kt) << (DLOG - SB);
    ph_half = PW'(kt) << (DLOG - SB + 1);
    p_new = full_steps ? ph_full[DLOG-1:0] : ph_half[DLOG-1:0];
  end

  // table lookups at p and at 2p or 3p
  logic [DLOG-1:0] p_mul;
  logic [DLOG-1:0] p_dbl;

  assign p_dbl = {p_q[DLOG-2:0], 1'b0};
  assign p_mul = (shape_q == pcs_pkg::ShapeHuygens) ? p_dbl + p_q : p_dbl;

  // shared multiplier: square, then cube, per axis
  logic signed [SW-1:0]              mul_b;
  logic signed [pcs_pkg::ProdBits-1:0] mul_a;
  logic signed [pcs_pkg::MulBits-1:0]  mul_res;

  assign mul_b   = cmd_i.mul_axis ? s_q : c_q;
  assign mul_a   = cmd_i.mul_cube ? prod_q : pcs_pkg::ProdBits'(mul_b);
  assign mul_res = mul_a * mul_b;

  // line shape runs over the half-length sweep
  logic [SB:0] line_n;
  assign line_n = (SB+1)'(pcs_pkg::HalfSteps) - {1'b0, k_q};

  logic signed [COORD_BITS-1:0] px, py;
  assign px = to_pixel(tx_q);
  assign py = to_pixel(ty_q);

  assign step_d = last_q ? '0 : k_q + SB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q    <= pcs_pkg::ShapeReset;
      center_x_q <= pcs_pkg::CenterXReset;
      center_y_q <= pcs_pkg::CenterYReset;
      step_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcs_pkg::CfgShape:   shape_q    <= cfg_data_i[pcs_pkg::ShapeBits-1:0];
          pcs_pkg::CfgCenterX: center_x_q <= cfg_data_i[pcs_pkg::CenterBits-1:0];
          pcs_pkg::CfgCenterY: center_y_q <= cfg_data_i[pcs_pkg::CenterBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q    <= k_new;
      last_q <= last_new;
      p_q    <= p_new;
    end
    if (cmd_i.look) begin
      c_q  <= sine_at(p_q + DLOG'(QD));
      s_q  <= sine_at(p_q);
      cm_q <= sine_at(p_mul + DLOG'(QD));
      sm_q <= sine_at(p_mul);
    end
    if (cmd_i.mul_en) begin
      if (!cmd_i.mul_cube) begin
        prod_q <= mul_res[pcs_pkg::ProdBits-1:0];
      end else if (cmd_i.mul_axis) begin
        cy3_q <= mul_res[pcs_pkg::CubeBits-1:0];
      end else begin
        cx3_q <= mul_res[pcs_pkg::CubeBits-1:0];
      end
    end
    if (cmd_i.sum) begin
      tx_q <= axis_sum(shape_q, c_q, cm_q, cx3_q, 1'b0, line_n, center_x_q);
      ty_q <= axis_sum(shape_q, s_q, sm_q, cy3_q, 1'b1, line_n, center_y_q);
    end
    if (cmd_i.finish) begin
      from_x_q   <= px;
      from_y_q   <= py;
      // step zero draws a point: the segment starts and ends on it
      to_x_q     <= (k_q == '0) ? px : prev_x_q;
      to_y_q     <= (k_q == '0) ? py : prev_y_q;
      out_last_q <= last_q;
      prev_x_q   <= px;
      prev_y_q   <= py;
    end
  end

  assign status_o.astroid = (shape_q == pcs_pkg::ShapeAstroid);

  assign from_x_o = from_x_q;
  assign from_y_o = from_y_q;
  assign to_x_o   = to_x_q;
  assign to_y_o   = to_y_q;
  assign last_o   = out_last_q;

endmodule

// ===== src/parametric_curve_sweep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parametric_curve_sweep: curve sampler, one line segment per item
// Steps through astroid, circle, Huygens cycloid, hypocycloid or line and
// returns the segment from the current pixel back to the previous one.
// ----------------------------------------------------------------------------
// Each input item yields one segment. Every item passes through lookup, sum
// and round before the next is accepted; the astroid also squares and cubes:
// its cosine and sine cubes go through a single shared 32x16 multiplier, one
// square or cube per cycle. The finished segment sits in an
// output register, so the next item is taken while it waits; an item reaches
// that register only once the previous segment has been taken. The register
// port is always ready and must only be written between sweeps' items, with
// no item in flight. There is no clearing pass after reset.
module parametric_curve_sweep #(
  parameter int SINE_TABLE_DEPTH = pcs_pkg::SineDepthDefault,
  parameter int COORD_BITS       = pcs_pkg::CoordBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcs_in_if.sink       in_i,
  pcs_out_if.source    out_o,
  pcs_cfg_if.sink      cfg_i
);

  pcs_pkg::pcs_cmd_t    cmd;
  pcs_pkg::pcs_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  pcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcs_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COORD_BITS       (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .restart_i   (in_i.restart),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .from_x_o    (out_o.from_x),
    .from_y_o    (out_o.from_y),
    .to_x_o      (out_o.to_x),
    .to_y_o      (out_o.to_y),
    .last_o      (out_o.last)
  );

`ifndef SYNTHESIS
  // a new segment never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid || out_o.ready))
    else $error("segment overwrote a pending result");

  // a segment appears only from a finished item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // an accepted item needs lookup, sum and rounding before it finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (!cmd.finish && !in_ready))
    else $error("item finished or input reopened right after acceptance");
`endif

endmodule
